// ===== hw/rtl/lpht_pkg.sv =====
// Shared constants, codes, types and the remainder step for the linear probe hash table.
package lpht_pkg;

	// Table geometry.
	localparam int SLOTS = 17;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int REM_W = IDX_W + 1;

	// Field widths of the item and result beats.
	localparam int KIND_W    = 2;
	localparam int KEY_W     = 31;
	localparam int VAL_W     = 32;
	localparam int STAT_W    = 3;
	localparam int CNT_OUT_W = 5;

	// Home slot reduction: the key is folded one byte per cycle.
	localparam int RADIX_W   = 8;
	localparam int MOD_STEPS = (KEY_W + RADIX_W - 1) / RADIX_W;
	localparam int HASH_W    = MOD_STEPS * RADIX_W;
	localparam int STEP_W    = $clog2(MOD_STEPS + 1);

	// Probe numbering runs a little past SLOTS because reads are issued one ahead.
	localparam int PRB_W  = $clog2(SLOTS + 3);
	localparam int LIVE_W = $clog2(SLOTS + 1);

	// Operation codes; the unused code behaves as a lookup.
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_NEW      = 3'd0;
	localparam logic [STAT_W-1:0] STAT_REPLACED = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FOUND    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_MISSING  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;

	// Slot occupancy codes.
	localparam logic [1:0] SLOT_EMPTY = 2'd0;
	localparam logic [1:0] SLOT_LIVE  = 2'd1;
	localparam logic [1:0] SLOT_TOMB  = 2'd2;

	// Verdict on one examined slot.
	typedef struct packed {
		logic              stop;   // search ends at this slot
		logic              hit;    // live slot holding the searched key
		logic [STAT_W-1:0] stat;   // status if it ends here or the search gives up
	} dec_t;

	// Folds one byte into a running remainder modulo SLOTS, one bit per
	// conditional subtract.
	function automatic logic [IDX_W-1:0] mod_byte(input logic [IDX_W-1:0] r,
			input logic [RADIX_W-1:0] b);
		logic [REM_W-1:0] t;
		t = REM_W'(r);
		for (int i = RADIX_W - 1; i >= 0; i--) begin
			t = {t[IDX_W-1:0], b[i]};
			if (t >= REM_W'(SLOTS)) begin
				t = t - REM_W'(SLOTS);
			end
		end
		return t[IDX_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/lpht_ram.sv =====
// Generic simple dual port RAM with one write port and a registered read port.
module lpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/lpht_hash.sv =====
// Multi-cycle home slot unit: reduces the key modulo the slot count one byte per cycle.
module lpht_hash (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [lpht_pkg::KEY_W-1:0] key,
	output logic                       done,
	output logic [lpht_pkg::IDX_W-1:0] home
);

	logic                              active_q;
	logic                              done_q;
	logic [lpht_pkg::STEP_W-1:0]       cnt_q;
	logic [lpht_pkg::HASH_W-1:0]       shreg_q;
	logic [lpht_pkg::IDX_W-1:0]        rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				active_q <= 1'b1;
				cnt_q    <= lpht_pkg::STEP_W'(lpht_pkg::MOD_STEPS);
			end else if (active_q) begin
				cnt_q <= cnt_q - lpht_pkg::STEP_W'(1);
				if (cnt_q == lpht_pkg::STEP_W'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	// Most significant byte first, so the remainder is Horner's rule in base 256.
	always_ff @(posedge clk) begin
		if (go) begin
			shreg_q <= lpht_pkg::HASH_W'(key);
			rem_q   <= '0;
		end else if (active_q) begin
			shreg_q <= shreg_q << lpht_pkg::RADIX_W;
			rem_q   <= lpht_pkg::mod_byte(rem_q,
				shreg_q[lpht_pkg::HASH_W-1 -: lpht_pkg::RADIX_W]);
		end
	end

	assign done = done_q;
	assign home = rem_q;

endmodule

// ===== hw/rtl/lpht_cmp.sv =====
// Slot examiner: judges one probed slot against the searched key for the current operation.
module lpht_cmp (
	input  logic [lpht_pkg::KIND_W-1:0] kind,
	input  logic [1:0]                  slot_st,
	input  logic [lpht_pkg::KEY_W-1:0]  slot_key,
	input  logic [lpht_pkg::KEY_W-1:0]  key,
	output lpht_pkg::dec_t              dec
);

	logic live;
	logic key_eq;

	assign live   = (slot_st == lpht_pkg::SLOT_LIVE);
	assign key_eq = (slot_key == key);

	always_comb begin
		dec.hit = live && key_eq;
		if (kind == lpht_pkg::KIND_INSERT) begin
			// Any slot that is not live can take the pair; a tombstone is reused.
			dec.stop = !live || key_eq;
			if (!live) begin
				dec.stat = lpht_pkg::STAT_NEW;
			end else if (key_eq) begin
				dec.stat = lpht_pkg::STAT_REPLACED;
			end else begin
				dec.stat = lpht_pkg::STAT_FULL;
			end
		end else begin
			// Search passes over tombstones and stops only at an empty slot or a hit.
			dec.stop = (slot_st == lpht_pkg::SLOT_EMPTY) || dec.hit;
			dec.stat = dec.hit ? lpht_pkg::STAT_FOUND : lpht_pkg::STAT_MISSING;
		end
	end

endmodule

// ===== hw/rtl/linear_probe_hash_table.sv =====
// Top level of the open addressing hash table with linear probing.
// The hash unit folds the key into its home slot, then one slot per cycle is judged until the
// search ends, p (1 to SLOTS) being the slots examined; done is registered from the last one.
// Busy drops with done, so a new item is taken only once the last one is through;
// the receiver cannot stall, so results never hold up the sequencer.
// Reset: arst_n clears every slot to empty and the live count to zero, but not the RAMs.
module linear_probe_hash_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [lpht_pkg::KIND_W-1:0]       kind,
	input  logic [lpht_pkg::KEY_W-1:0]        key,
	input  logic signed [lpht_pkg::VAL_W-1:0] value,
	output logic                              done,
	output logic [lpht_pkg::STAT_W-1:0]       status,
	output logic signed [lpht_pkg::VAL_W-1:0] found_value,
	output logic [lpht_pkg::CNT_OUT_W-1:0]    probe_count,
	output logic [lpht_pkg::CNT_OUT_W-1:0]    entry_count
);

	// Sequencer states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_HASH  = 3'b010,
		ST_PROBE = 3'b100
	} state_t;

	state_t                            state_q;

	// Operation under way, captured from the accepted beat.
	logic [lpht_pkg::KIND_W-1:0]       kind_q;
	logic [lpht_pkg::KEY_W-1:0]        key_q;
	logic [lpht_pkg::VAL_W-1:0]        value_q;

	// Read issue side: the next slot to read and its probe number.
	logic [lpht_pkg::IDX_W-1:0]        idx_q;
	logic [lpht_pkg::PRB_W-1:0]        issued_q;

	// Judge stage: the slot whose RAM data is arriving this cycle.
	logic                              v_s1;
	logic [lpht_pkg::IDX_W-1:0]        idx_s1;
	logic [1:0]                        slot_s1;
	logic [lpht_pkg::PRB_W-1:0]        probe_s1;

	// Occupancy of every slot lives in flops so that reset can clear it at once.
	logic [1:0]                        slot_st_q [lpht_pkg::SLOTS];
	logic [lpht_pkg::LIVE_W-1:0]       live_q;
	logic [lpht_pkg::LIVE_W-1:0]       live_nxt;

	// Result beat registers.
	logic                              done_q;
	logic [lpht_pkg::STAT_W-1:0]       status_q;
	logic [lpht_pkg::VAL_W-1:0]        found_q;
	logic [lpht_pkg::CNT_OUT_W-1:0]    probe_q;
	logic [lpht_pkg::CNT_OUT_W-1:0]    entry_q;

	logic                              accept;
	logic                              hash_done;
	logic [lpht_pkg::IDX_W-1:0]        home;
	logic                              rd_en;
	logic [lpht_pkg::IDX_W-1:0]        idx_next;
	logic [lpht_pkg::KEY_W-1:0]        rd_key;
	logic [lpht_pkg::VAL_W-1:0]        rd_value;
	lpht_pkg::dec_t                    dec;
	logic                              finish;
	logic                              ins_write;
	logic                              del_write;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Home slot: key modulo SLOTS, folded byte by byte.
	lpht_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (accept),
		.key    (key),
		.done   (hash_done),
		.home   (home)
	);

	// Probing walks forward one slot per cycle and wraps from the last slot to slot zero.
	assign idx_next = (idx_q == lpht_pkg::IDX_W'(lpht_pkg::SLOTS - 1)) ?
		'0 : idx_q + lpht_pkg::IDX_W'(1);
	assign rd_en = (state_q == ST_PROBE);

	// The search ends at a deciding slot, or after the last of SLOTS probes.
	assign finish = (state_q == ST_PROBE) && v_s1 &&
		(dec.stop || (probe_s1 == lpht_pkg::PRB_W'(lpht_pkg::SLOTS)));

	// An insert writes the pair at the slot that stopped it, new or replaced alike.
	// A delete that hits turns its slot into a tombstone.
	assign ins_write = finish && dec.stop && (kind_q == lpht_pkg::KIND_INSERT);
	assign del_write = finish && dec.hit && (kind_q == lpht_pkg::KIND_DELETE);

	lpht_ram #(
		.WIDTH (lpht_pkg::KEY_W),
		.DEPTH (lpht_pkg::SLOTS)
	) u_key_ram (
		.clk   (clk),
		.we    (ins_write),
		.waddr (idx_s1),
		.wdata (key_q),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (rd_key)
	);

	lpht_ram #(
		.WIDTH (lpht_pkg::VAL_W),
		.DEPTH (lpht_pkg::SLOTS)
	) u_value_ram (
		.clk   (clk),
		.we    (ins_write),
		.waddr (idx_s1),
		.wdata (value_q),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (rd_value)
	);

	// One shared comparator judges the slot whose data has just come out of the RAMs.
	lpht_cmp u_cmp (
		.kind     (kind_q),
		.slot_st  (slot_s1),
		.slot_key (rd_key),
		.key      (key_q),
		.dec      (dec)
	);

	// Live entries rise on a fresh insert and fall on a delete hit.
	always_comb begin
		live_nxt = live_q;
		if (ins_write && !dec.hit) begin
			live_nxt = live_q + lpht_pkg::LIVE_W'(1);
		end else if (del_write) begin
			live_nxt = live_q - lpht_pkg::LIVE_W'(1);
		end
	end

	// Sequencer, slot occupancy and live count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
			done_q  <= 1'b0;
			live_q  <= '0;
			for (int i = 0; i < lpht_pkg::SLOTS; i++) begin
				slot_st_q[i] <= lpht_pkg::SLOT_EMPTY;
			end
		end else begin
			done_q <= finish;
			v_s1   <= (state_q == ST_PROBE);
			live_q <= live_nxt;
			if (ins_write) begin
				slot_st_q[idx_s1] <= lpht_pkg::SLOT_LIVE;
			end else if (del_write) begin
				slot_st_q[idx_s1] <= lpht_pkg::SLOT_TOMB;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operands, probe addresses and the judge stage, but for its valid flag, carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind;
			key_q   <= key;
			value_q <= value;
		end
		if ((state_q == ST_HASH) && hash_done) begin
			idx_q    <= home;
			issued_q <= lpht_pkg::PRB_W'(1);
		end else if (state_q == ST_PROBE) begin
			idx_q    <= idx_next;
			issued_q <= issued_q + lpht_pkg::PRB_W'(1);
		end
		if (state_q == ST_PROBE) begin
			idx_s1   <= idx_q;
			slot_s1  <= slot_st_q[idx_q];
			probe_s1 <= issued_q;
		end
	end

	// The result beat is built in the cycle the search ends and shown for one cycle.
	always_ff @(posedge clk) begin
		if (finish) begin
			status_q <= dec.stat;
			found_q  <= (dec.hit && (kind_q != lpht_pkg::KIND_INSERT)) ? rd_value : '0;
			probe_q  <= lpht_pkg::CNT_OUT_W'(probe_s1);
			entry_q  <= lpht_pkg::CNT_OUT_W'(live_nxt);
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_value = found_q;
	assign probe_count = probe_q;
	assign entry_count = entry_q;

	// The result beat appears only once the sequencer is free again.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result beat while the sequencer is busy");

	// Accepting an item makes the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy)
		else $error("accepted item did not start the sequencer");

	// The live count never exceeds the number of slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= lpht_pkg::LIVE_W'(lpht_pkg::SLOTS))
		else $error("live count beyond slot count");

	// A slot is never judged past the last permitted probe.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) && v_s1 |-> probe_s1 <= lpht_pkg::PRB_W'(lpht_pkg::SLOTS))
		else $error("probe count ran past the slot count");

	// A full table is only reported after every slot was examined.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == lpht_pkg::STAT_FULL) |->
		probe_count == lpht_pkg::CNT_OUT_W'(lpht_pkg::SLOTS))
		else $error("table full reported before all slots were probed");

endmodule
